### rtl/cfl_adaptive_timestep_macros.svh
// Assertion macros used by the port-level checker of the step controller.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef CFL_ADAPTIVE_TIMESTEP_MACROS_SVH
`define CFL_ADAPTIVE_TIMESTEP_MACROS_SVH

// checked only outside reset
`define CFL_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// checked at every edge, reset included
`define CFL_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) \
		else $error(msg);

`endif

### rtl/cfl_pkg.sv
// Shared types and constants of the CFL step controller.
// No dependencies.
package cfl_pkg;

	localparam int MAX_DIMS  = 3;
	localparam int NUM_LANES = MAX_DIMS;
	localparam int DIMS_W    = 2;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_CFL_NUMBER    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DT_MIN        = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DT_MAX        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GROWTH_FACTOR = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DIMENSIONS    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_INITIAL_DT    = 3'd5;

	localparam logic [31:0] RST_CFL_NUMBER    = 32'd16777216;
	localparam logic [31:0] RST_DT_MIN        = 32'd1;
	localparam logic [31:0] RST_DT_MAX        = 32'd16777216;
	localparam logic [15:0] RST_GROWTH_FACTOR = 16'd6554;
	localparam logic [DIMS_W-1:0] RST_DIMENSIONS = 2'd3;
	localparam logic [31:0] RST_INITIAL_DT    = 32'd16777;

	// restoring divider: 48-bit dividend, 32-bit divisor
	localparam int DIV_W     = 48;
	localparam int DIV_CNT_W = 6;
	// integer square root of 64 bits, two bits per step
	localparam int SQRT_STEPS = 32;
	localparam int SQRT_CNT_W = 6;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quo;
	} div_res_t;

	typedef struct packed {
		logic        done;
		logic [31:0] root;
	} sqrt_res_t;

	typedef struct packed {
		logic        done;
		logic [63:0] sq;
	} lane_res_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LANE,
		ST_MAX,
		ST_SQRT,
		ST_DIVGO,
		ST_DIV,
		ST_GROW,
		ST_ADAPT,
		ST_OUT
	} ctl_state_t;

endpackage

### rtl/cfl_if.sv
// Valid/ready channel interfaces for grid points and step results.
// No dependencies.
interface cfl_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] vel_x;
	logic signed [31:0] vel_y;
	logic signed [31:0] vel_z;
	logic [31:0]        grid_scale;
	logic               last_point;

	modport source(output valid, vel_x, vel_y, vel_z, grid_scale, last_point, input ready);
	modport sink(input valid, vel_x, vel_y, vel_z, grid_scale, last_point, output ready);
endinterface

interface cfl_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] new_step;
	logic [31:0] peak_speed;
	logic        runaway;

	modport source(output valid, new_step, peak_speed, runaway, input ready);
	modport sink(input valid, new_step, peak_speed, runaway, output ready);
endinterface

### rtl/cfl_adaptive_timestep.sv
// Top level of the CFL step controller: config registers, lanes, merge, final update.
// Depends on cfl_pkg, cfl_if, cfl_lane, cfl_merge, cfl_isqrt, cfl_div.
//
// One grid point is in flight at a time. The next point can be taken once the
// lane dividers that form |u|/h for all three components side by side have
// finished. A point that closes a sweep adds the square root and a second
// divide for dtInst, after which the result goes to an output register; the
// input side takes the next point while that result waits. A step result only
// waits in the final stage if the previous one is still held.
// Writing initial_dt also reloads the stored step.
module cfl_adaptive_timestep (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [cfl_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [cfl_pkg::CFG_DATA_W-1:0] cfg_data,
	cfl_in_if.sink                         in_ch,
	cfl_out_if.source                      out_ch
);
	import cfl_pkg::*;

	ctl_state_t state_q, state_nxt;

	logic [31:0]       cfl_q, dt_min_q, dt_max_q, step_q;
	logic [15:0]       gf_q;
	logic [DIMS_W-1:0] dims_q;
	logic [63:0]       max_q;

	logic        last_q;
	logic [31:0] peak_q, inst_q, dta_q;
	logic [47:0] prod_q;
	logic        out_valid_q, runaway_q;
	logic [31:0] out_step_q, out_peak_q;

	logic        in_ready, lane_start, sqrt_start, div_start, out_load, lanes_done;
	lane_res_t   lane_res [NUM_LANES];
	logic signed [31:0] lane_vel [NUM_LANES];
	logic [63:0] sum_s1, newmax;
	sqrt_res_t   sqrt_res;
	div_res_t    div_res;
	logic [32:0] g33;
	logic [31:0] g, dta, dtc;

	assign lane_vel[0] = in_ch.vel_x;
	assign lane_vel[1] = in_ch.vel_y;
	assign lane_vel[2] = in_ch.vel_z;

	for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
		cfl_lane u_lane (
			.clk   (clk),
			.arst_n(arst_n),
			.start (lane_start),
			.vel   (lane_vel[i]),
			.scale (in_ch.grid_scale),
			.res   (lane_res[i])
		);
	end

	always_comb begin
		lanes_done = 1'b1;
		for (int i = 0; i < NUM_LANES; i++)
			lanes_done = lanes_done & lane_res[i].done;
	end

	cfl_merge u_merge (
		.clk   (clk),
		.en    (lanes_done),
		.dims  (dims_q),
		.lanes (lane_res),
		.sum_s1(sum_s1)
	);

	assign newmax = (sum_s1 > max_q) ? sum_s1 : max_q;

	cfl_isqrt u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (sqrt_start),
		.radicand(newmax),
		.res     (sqrt_res)
	);

	// dtInst = cfl * 2^15 / peak
	cfl_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend({1'b0, cfl_q, 15'h0000}),
		.divisor (peak_q),
		.res     (div_res)
	);

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_ch.valid) state_nxt = ST_LANE;
			ST_LANE:  if (lanes_done) state_nxt = ST_MAX;
			ST_MAX:   state_nxt = last_q ? ST_SQRT : ST_IDLE;
			ST_SQRT:  if (sqrt_res.done) state_nxt = ST_DIVGO;
			ST_DIVGO: state_nxt = ST_DIV;
			ST_DIV:   if (div_res.done) state_nxt = ST_GROW;
			ST_GROW:  state_nxt = ST_ADAPT;
			ST_ADAPT: state_nxt = ST_OUT;
			ST_OUT:   if (!out_valid_q || out_ch.ready) state_nxt = ST_IDLE;
			default:  state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready   = (state_q == ST_IDLE);
		lane_start = in_ready && in_ch.valid;
		sqrt_start = (state_q == ST_MAX) && last_q;
		div_start  = (state_q == ST_DIVGO);
		out_load   = (state_q == ST_OUT) && (!out_valid_q || out_ch.ready);
	end

	assign in_ch.ready = in_ready;

	assign g33 = {1'b0, step_q} + {1'b0, prod_q[47:16]};
	assign g   = g33[32] ? '1 : g33[31:0];
	assign dta = (inst_q > step_q) ? ((g < inst_q) ? g : inst_q) : inst_q;
	assign dtc = (dta_q > dt_max_q) ? dt_max_q : dta_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cfl_q       <= RST_CFL_NUMBER;
			dt_min_q    <= RST_DT_MIN;
			dt_max_q    <= RST_DT_MAX;
			gf_q        <= RST_GROWTH_FACTOR;
			dims_q      <= RST_DIMENSIONS;
			step_q      <= RST_INITIAL_DT;
			max_q       <= 64'd1;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cfg_we) begin
				case (cfg_idx)
					REG_CFL_NUMBER:    cfl_q    <= cfg_data;
					REG_DT_MIN:        dt_min_q <= cfg_data;
					REG_DT_MAX:        dt_max_q <= cfg_data;
					REG_GROWTH_FACTOR: gf_q     <= cfg_data[15:0];
					REG_DIMENSIONS:    dims_q   <= cfg_data[DIMS_W-1:0];
					REG_INITIAL_DT:    step_q   <= cfg_data;
					default: ;
				endcase
			end
			// end of sweep puts the maximum back on its floor
			if (state_q == ST_MAX)
				max_q <= last_q ? 64'd1 : newmax;
			if (out_load)
				step_q <= dtc;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ch.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (lane_start)
			last_q <= in_ch.last_point;
		if (sqrt_res.done && state_q == ST_SQRT)
			peak_q <= (sqrt_res.root == '0) ? 32'd1 : sqrt_res.root;
		if (div_res.done && state_q == ST_DIV)
			inst_q <= (|div_res.quo[DIV_W-1:32]) ? '1 : div_res.quo[31:0];
		if (state_q == ST_GROW)
			prod_q <= step_q * gf_q;
		if (state_q == ST_ADAPT)
			dta_q <= dta;
		if (out_load) begin
			out_step_q <= dtc;
			out_peak_q <= peak_q;
			runaway_q  <= (dtc < dt_min_q);
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.new_step   = out_step_q;
	assign out_ch.peak_speed = out_peak_q;
	assign out_ch.runaway    = runaway_q;
endmodule

### rtl/cfl_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on cfl_pkg.
module cfl_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [cfl_pkg::DIV_W-1:0] dividend,
	input  logic [31:0]               divisor,
	output cfl_pkg::div_res_t         res
);
	import cfl_pkg::*;

	localparam logic [DIV_CNT_W-1:0] DIV_STEPS = DIV_CNT_W'(DIV_W);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [31:0]          rem_q;
	logic [DIV_W-1:0]     dvd_q;
	logic [31:0]          d_q;

	logic [32:0] shifted;
	logic [32:0] diff;
	logic        ge;
	logic [31:0] rem_nxt;

	assign shifted = {rem_q, dvd_q[DIV_W-1]};
	assign diff    = shifted - {1'b0, d_q};
	assign ge      = shifted >= {1'b0, d_q};
	assign rem_nxt = ge ? diff[31:0] : shifted[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_STEPS;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// quotient bits shift in where dividend bits leave
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			d_q   <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_nxt;
			dvd_q <= {dvd_q[DIV_W-2:0], ge};
		end
	end

	assign res.done = done_q;
	assign res.quo  = dvd_q;
endmodule

### rtl/cfl_isqrt.sv
// Iterative floor square root of a 64-bit value, two radicand bits per cycle.
// Depends on cfl_pkg.
module cfl_isqrt (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [63:0]        radicand,
	output cfl_pkg::sqrt_res_t res
);
	import cfl_pkg::*;

	localparam logic [SQRT_CNT_W-1:0] STEPS = SQRT_CNT_W'(SQRT_STEPS);

	logic                  busy_q;
	logic                  done_q;
	logic [SQRT_CNT_W-1:0] cnt_q;
	logic [63:0]           x_q;
	logic [33:0]           rem_q;
	logic [31:0]           root_q;

	logic [35:0] shifted;
	logic [35:0] trial;
	logic [35:0] diff;
	logic        ge;

	assign shifted = {rem_q, x_q[63:62]};
	assign trial   = {2'b00, root_q, 2'b01};
	assign diff    = shifted - trial;
	assign ge      = shifted >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= STEPS;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == SQRT_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			x_q    <= {x_q[61:0], 2'b00};
			rem_q  <= ge ? diff[33:0] : shifted[33:0];
			root_q <= {root_q[30:0], ge};
		end
	end

	assign res.done = done_q;
	assign res.root = root_q;
endmodule

### rtl/cfl_lane.sv
// One velocity lane: |u|/h through a private divider, saturated, then squared.
// Depends on cfl_pkg and cfl_div.
module cfl_lane (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [31:0] vel,
	input  logic [31:0]        scale,
	output cfl_pkg::lane_res_t res
);
	import cfl_pkg::*;

	logic [31:0] mag;
	div_res_t    div_res;
	logic        h_zero_q;
	logic [31:0] q_q;
	logic        sq_pend_q;
	logic        done_q;
	logic [63:0] sq_q;

	// two's complement magnitude, most negative value maps onto itself
	assign mag = vel[31] ? 32'(-vel) : 32'(vel);

	cfl_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.dividend({mag, 16'h0000}),
		.divisor (scale),
		.res     (div_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_pend_q <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			sq_pend_q <= div_res.done;
			done_q    <= sq_pend_q;
		end
	end

	always_ff @(posedge clk) begin
		if (start)
			h_zero_q <= (scale == '0);
		if (div_res.done)
			q_q <= (h_zero_q || (|div_res.quo[DIV_W-1:32])) ? '1 : div_res.quo[31:0];
		if (sq_pend_q)
			sq_q <= q_q * q_q;
	end

	assign res.done = done_q;
	assign res.sq   = sq_q;
endmodule

### rtl/cfl_merge.sv
// Merging stage: saturating sum of the enabled lanes' squares, registered.
// Depends on cfl_pkg.
module cfl_merge (
	input  logic                       clk,
	input  logic                       en,
	input  logic [cfl_pkg::DIMS_W-1:0] dims,
	input  cfl_pkg::lane_res_t         lanes [cfl_pkg::NUM_LANES],
	output logic [63:0]                sum_s1
);
	import cfl_pkg::*;

	logic [63:0] acc;

	always_comb begin
		logic [64:0] tmp;
		logic [63:0] term;
		acc = '0;
		for (int i = 0; i < NUM_LANES; i++) begin
			term = (DIMS_W'(i) < dims) ? lanes[i].sq : 64'd0;
			tmp  = {1'b0, acc} + {1'b0, term};
			acc  = tmp[64] ? '1 : tmp[63:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			sum_s1 <= acc;
	end
endmodule

### rtl/cfl_checker.sv
// Port-level checks of the step controller, bound to the top level.
// Depends on cfl_pkg and cfl_adaptive_timestep_macros.svh.
`include "cfl_adaptive_timestep_macros.svh"

module cfl_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           cfg_we,
	input logic [cfl_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input logic [cfl_pkg::CFG_DATA_W-1:0] cfg_data,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic [31:0]                    new_step,
	input logic [31:0]                    peak_speed,
	input logic                           runaway
);
	import cfl_pkg::*;

	logic [31:0] dt_max_q;

	// shadow of the step ceiling as written through the config port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			dt_max_q <= RST_DT_MAX;
		else if (cfg_we && cfg_idx == REG_DT_MAX)
			dt_max_q <= cfg_data;
	end

	`CFL_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(new_step) && $stable(peak_speed) && $stable(runaway), "result changed while stalled")
	`CFL_ASSERT(a_peak_nonzero, out_valid |-> peak_speed != 32'd0, "peak speed of zero reported")
	`CFL_ASSERT(a_step_ceiling, out_valid |-> new_step <= dt_max_q, "step above dt_max")
	`CFL_ASSERT_ALWAYS(a_reset_idle, !arst_n |=> !out_valid, "result valid right after reset")
endmodule

bind cfl_adaptive_timestep cfl_checker u_cfl_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cfg_we    (cfg_we),
	.cfg_idx   (cfg_idx),
	.cfg_data  (cfg_data),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.new_step  (out_ch.new_step),
	.peak_speed(out_ch.peak_speed),
	.runaway   (out_ch.runaway)
);

### bench/cfl_adaptive_timestep_checker.sv
// Checker for the CFL step controller: watches the config port and both channels.
// It predicts each step result and compares it field by field.
// Depends on cfl_pkg and cfl_if.
`timescale 1ns / 1ps

module cfl_adaptive_timestep_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [cfl_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [cfl_pkg::CFG_DATA_W-1:0] cfg_data,
	cfl_in_if                              in_ch,
	cfl_out_if                             out_ch,
	output int                             errors,
	output int                             pending,
	output int                             points_seen,
	output int                             steps_seen,
	output int                             runaways_seen
);
	import cfl_pkg::*;

	typedef struct packed {
		logic [31:0] new_step;
		logic [31:0] peak_speed;
		logic        runaway;
	} step_res_t;

	logic [31:0]       cfl_q;
	logic [31:0]       dt_lo;
	logic [31:0]       dt_hi;
	logic [15:0]       grow_q;
	logic [DIMS_W-1:0] dims_q;
	logic [63:0]       peak_sq;
	logic [31:0]       step_q;
	step_res_t         step_fifo[$];

	function automatic logic [31:0] scaled_speed(logic [31:0] v, logic [31:0] h);
		logic [31:0] mag;
		logic [63:0] q;
		mag = v[31] ? (~v + 32'd1) : v;
		if (h == 32'd0)
			return 32'hFFFF_FFFF;
		q = {16'd0, mag, 16'd0} / {32'd0, h};
		return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
	endfunction

	function automatic logic [63:0] root64(logic [63:0] x);
		logic [63:0] r;
		logic [63:0] b;
		r = 64'd0;
		b = 64'd1 << 62;
		while (b > x)
			b = b >> 2;
		while (b != 64'd0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic bit check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
			return 1'b0;
		end
		return 1'b1;
	endfunction

	always @(posedge clk) begin
		logic [64:0] sum;
		logic [63:0] sq;
		logic [63:0] peak;
		logic [63:0] inst;
		logic [63:0] dt;
		logic [63:0] grown;
		int          nd;
		step_res_t   exp_r;
		bit          ok;
		if (!arst_n) begin
			cfl_q   <= RST_CFL_NUMBER;
			dt_lo   <= RST_DT_MIN;
			dt_hi   <= RST_DT_MAX;
			grow_q  <= RST_GROWTH_FACTOR;
			dims_q  <= RST_DIMENSIONS;
			peak_sq <= 64'd1;
			step_q  <= RST_INITIAL_DT;
			errors  = 0;
			pending = 0;
			points_seen = 0;
			steps_seen = 0;
			runaways_seen = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_CFL_NUMBER:    cfl_q  <= cfg_data;
					REG_DT_MIN:        dt_lo  <= cfg_data;
					REG_DT_MAX:        dt_hi  <= cfg_data;
					REG_GROWTH_FACTOR: grow_q <= cfg_data[15:0];
					REG_DIMENSIONS:    dims_q <= cfg_data[DIMS_W-1:0];
					REG_INITIAL_DT:    step_q <= cfg_data;
					default: ;
				endcase
			end
			if (in_ch.valid && in_ch.ready) begin
				points_seen++;
				nd = (dims_q > MAX_DIMS) ? MAX_DIMS : dims_q;
				sum = 65'd0;
				for (int i = 0; i < nd; i++) begin
					sq = 64'(scaled_speed(i == 0 ? in_ch.vel_x : i == 1 ? in_ch.vel_y : in_ch.vel_z,
						in_ch.grid_scale)) ** 2;
					sum = sum + {1'b0, sq};
					if (sum[64])
						sum = {1'b0, 64'hFFFF_FFFF_FFFF_FFFF};
				end
				sq = (sum[63:0] > peak_sq) ? sum[63:0] : peak_sq;
				if (!in_ch.last_point) begin
					peak_sq <= sq;
				end else begin
					peak = root64(sq);
					if (peak == 64'd0)
						peak = 64'd1;
					inst = ({32'd0, cfl_q} << 15) / peak;
					if (inst > 64'hFFFF_FFFF)
						inst = 64'hFFFF_FFFF;
					dt = {32'd0, step_q};
					if (inst > dt) begin
						grown = dt + ((dt * {48'd0, grow_q}) >> 16);
						if (grown > 64'hFFFF_FFFF)
							grown = 64'hFFFF_FFFF;
						dt = (grown < inst) ? grown : inst;
					end else if (inst < dt) begin
						dt = inst;
					end
					if (dt > {32'd0, dt_hi})
						dt = {32'd0, dt_hi};
					exp_r.new_step   = dt[31:0];
					exp_r.peak_speed = peak[31:0];
					exp_r.runaway    = (dt[31:0] < dt_lo);
					step_fifo.push_back(exp_r);
					step_q  <= dt[31:0];
					peak_sq <= 64'd1;
				end
			end
			if (out_ch.valid && out_ch.ready) begin
				steps_seen++;
				if (step_fifo.size() == 0) begin
					$display("%0t: step result with none expected: step %h peak %h runaway %b",
						$time, out_ch.new_step, out_ch.peak_speed, out_ch.runaway);
					errors++;
				end else begin
					exp_r = step_fifo.pop_front();
					if (out_ch.runaway === 1'b1)
						runaways_seen++;
					ok = check_field("new_step", exp_r.new_step, out_ch.new_step);
					ok &= check_field("peak_speed", exp_r.peak_speed, out_ch.peak_speed);
					ok &= check_field("runaway", {31'd0, exp_r.runaway}, {31'd0, out_ch.runaway});
					if (!ok)
						errors++;
				end
			end
			pending = step_fifo.size();
		end
	end
endmodule

### bench/cfl_adaptive_timestep_test.sv
// Top of the CFL step controller bench: clock, reset, config writes and stimulus.
// Depends on cfl_pkg, cfl_if, cfl_adaptive_timestep and its checker.
`timescale 1ns / 1ps

module cfl_adaptive_timestep_test;
	import cfl_pkg::*;

	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int DRAIN_CYCLES = 200;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	int                    src_idle = 0;
	int                    dst_idle = 0;
	bit                    stall_go = 1'b0;
	bit                    stall_on = 1'b0;
	int                    errors, pending, points_seen, steps_seen, runaways_seen;
	int                    cycles = 0;

	cfl_in_if  in_ch();
	cfl_out_if out_ch();

	cfl_adaptive_timestep u_top (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch)
	);

	cfl_adaptive_timestep_checker u_checker (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch), .errors(errors),
		.pending(pending), .points_seen(points_seen), .steps_seen(steps_seen),
		.runaways_seen(runaways_seen)
	);

	always #6 clk = ~clk;

	initial begin
		in_ch.valid = 1'b0;
		in_ch.vel_x = '0;
		in_ch.vel_y = '0;
		in_ch.vel_z = '0;
		in_ch.grid_scale = 32'h0001_0000;
		in_ch.last_point = 1'b0;
		out_ch.ready = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d steps outstanding", cycles, pending);
			$display("Regression FAIL");
			$finish;
		end
	end

	always @(posedge clk)
		out_ch.ready <= !stall_on && ($urandom_range(99) >= dst_idle);

	// long receiver hold-off so the output side backs up into the input
	initial begin
		wait (stall_go);
		stall_on = 1'b1;
		repeat (700) @(posedge clk);
		stall_on = 1'b0;
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// waits for all steps and for any point still in the lanes
	task automatic settle();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic send_point(logic [31:0] vx, logic [31:0] vy, logic [31:0] vz,
		logic [31:0] h, logic last);
		while ($urandom_range(99) < src_idle) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid      <= 1'b1;
		in_ch.vel_x      <= vx;
		in_ch.vel_y      <= vy;
		in_ch.vel_z      <= vz;
		in_ch.grid_scale <= h;
		in_ch.last_point <= last;
		do
			@(posedge clk);
		while (!in_ch.ready);
	endtask

	function automatic logic [31:0] pick_velocity();
		case ($urandom_range(5))
			0: return $urandom();
			1: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
			2: return 32'($urandom_range(0, 32'h40_0000)) - 32'h20_0000;
			default: return 32'($urandom_range(0, 32'h8_0000)) - 32'h4_0000;
		endcase
	endfunction

	function automatic logic [31:0] pick_scale();
		case ($urandom_range(9))
			0: return $urandom() | 32'd1;
			1: return $urandom_range(1) ? 32'd1 : 32'hFFFF_FFFF;
			2: return $urandom_range(1, 32'h100);
			default: return $urandom_range(32'h1000, 32'h8_0000);
		endcase
	endfunction

	task automatic load_config(int ph);
		case (ph % 6)
			0: begin
				write_reg(REG_CFL_NUMBER, 32'h0080_0000);
				write_reg(REG_DT_MIN, 32'h0000_0100);
				write_reg(REG_DT_MAX, 32'h0400_0000);
				write_reg(REG_GROWTH_FACTOR, 32'h0000_4000);
				write_reg(REG_DIMENSIONS, 32'd2);
				write_reg(REG_INITIAL_DT, 32'h0000_1000);
			end
			1: begin
				write_reg(REG_CFL_NUMBER, 32'hFFFF_FFFF);
				write_reg(REG_DT_MAX, 32'hFFFF_FFFF);
				write_reg(REG_GROWTH_FACTOR, 32'h0000_FFFF);
				write_reg(REG_DIMENSIONS, 32'd3);
				write_reg(REG_INITIAL_DT, 32'hFFFF_FFFF);
			end
			2: begin
				write_reg(REG_CFL_NUMBER, 32'd0);
				write_reg(REG_DT_MIN, 32'd0);
				write_reg(REG_GROWTH_FACTOR, 32'd0);
				write_reg(REG_DIMENSIONS, 32'd1);
				write_reg(REG_INITIAL_DT, 32'd0);
			end
			3: begin
				write_reg(REG_CFL_NUMBER, $urandom());
				write_reg(REG_DT_MIN, 32'hFFFF_FFFF);
				write_reg(REG_DT_MAX, 32'd0);
				write_reg(REG_DIMENSIONS, 32'hFFFF_FFFC);
			end
			4: begin
				write_reg(REG_CFL_NUMBER, 32'h0100_0000);
				write_reg(REG_DT_MIN, 32'h0001_0000);
				write_reg(REG_DT_MAX, 32'h0100_0000);
				write_reg(REG_GROWTH_FACTOR, $urandom());
				write_reg(REG_DIMENSIONS, 32'd3);
				write_reg(REG_INITIAL_DT, $urandom());
			end
			default: begin
				write_reg(REG_CFL_NUMBER, $urandom());
				write_reg(REG_DT_MIN, $urandom_range(0, 32'h1000));
				write_reg(REG_DT_MAX, $urandom());
				write_reg(REG_GROWTH_FACTOR, $urandom_range(0, 16'hFFFF));
				write_reg(REG_DIMENSIONS, $urandom_range(0, 3));
				write_reg(3'd6, $urandom());
				write_reg(3'd7, $urandom());
			end
		endcase
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset config first, then extremes of velocity and scale
		send_point(32'd0, 32'd0, 32'd0, 32'h0001_0000, 1'b1);
		send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'd1, 1'b0);
		send_point(32'h0001_0000, 32'hFFFF_0000, 32'd1, 32'h0001_0000, 1'b1);
		send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1);
		send_point(32'd5, 32'd7, 32'd9, 32'd0, 1'b1);
		send_point(32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, 32'h0000_8000, 1'b0);
		send_point(32'h0000_1000, 32'h0000_2000, 32'h0000_3000, 32'h0002_0000, 1'b1);
		settle();
		write_reg(REG_DIMENSIONS, 32'd0);
		send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd1, 1'b1);
		settle();
		write_reg(REG_DIMENSIONS, 32'd1);
		write_reg(REG_DT_MIN, 32'hFFFF_FFFF);
		send_point(32'h0000_8000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0001_0000, 1'b1);
		send_point(32'h0000_8000, 32'd0, 32'd0, 32'h0001_0000, 1'b1);
		settle();
		write_reg(REG_DT_MIN, 32'd1);
		write_reg(REG_INITIAL_DT, 32'hFFFF_FFFF);
		write_reg(3'd6, 32'hDEAD_BEEF);
		send_point(32'd0, 32'd0, 32'd0, 32'h0001_0000, 1'b1);
		send_point(32'd0, 32'd0, 32'd0, 32'h0001_0000, 1'b1);
		settle();

		for (int ph = 0; ph < 6; ph++) begin
			src_idle = (ph < 2) ? 18 : (ph < 4) ? 49 : 0;
			dst_idle = (ph < 2) ? 49 : (ph < 4) ? 18 : 0;
			load_config(ph);
			for (int n = 0; n < 315; n++) begin
				if (ph == 4 && n == 40)
					stall_go = 1'b1;
				send_point(pick_velocity(), pick_velocity(), pick_velocity(), pick_scale(),
					$urandom_range(7) == 0);
			end
			settle();
		end

		$display("Covered %0d grid points, %0d step results, %0d with the runaway flag set.",
			points_seen, steps_seen, runaways_seen);
		$display("Six register settings from zero to full scale, with idle and stall mixes.");
		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("%0d mismatches", errors);
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule

### cfl_adaptive_timestep.f
+incdir+rtl
rtl/cfl_pkg.sv
rtl/cfl_if.sv
rtl/cfl_div.sv
rtl/cfl_isqrt.sv
rtl/cfl_lane.sv
rtl/cfl_merge.sv
rtl/cfl_adaptive_timestep.sv
rtl/cfl_checker.sv
bench/cfl_adaptive_timestep_checker.sv
bench/cfl_adaptive_timestep_test.sv
